>>> src/alpha_weighted_area_resize_core_macros.svh
// Assertion macros shared by the alpha-weighted area resize RTL.
// Included by every file that carries concurrent assertions; no other dependencies.
`ifndef ALPHA_WEIGHTED_AREA_RESIZE_CORE_MACROS_SVH
`define ALPHA_WEIGHTED_AREA_RESIZE_CORE_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked on every rising edge outside reset.
`define AWR_ASSERT_IMP(label, clk_s, rstn_s, pre, post) \
    label: assert property (@(posedge clk_s) disable iff (!rstn_s) (pre) |-> (post)) \
        else $error("awr assertion failed");
// Next-cycle implication, checked on every rising edge outside reset.
`define AWR_ASSERT_NXT(label, clk_s, rstn_s, pre, post) \
    label: assert property (@(posedge clk_s) disable iff (!rstn_s) (pre) |=> (post)) \
        else $error("awr assertion failed");
`else
`define AWR_ASSERT_IMP(label, clk_s, rstn_s, pre, post)
`define AWR_ASSERT_NXT(label, clk_s, rstn_s, pre, post)
`endif
`endif

>>> src/awr_pkg.sv
// Shared types, widths and helper functions of the alpha-weighted area resize core.
// No dependencies; compiled before all other files.
`default_nettype none
package awr_pkg;

    localparam int MAX_SOURCE_WIDTH_DEF  = 256;
    localparam int MAX_SOURCE_HEIGHT_DEF = 256;
    localparam int MAX_TARGET_DIM_DEF    = 4096;

    localparam int COORD_W    = 12;
    localparam int CHAN_W     = 8;
    localparam int SRC_DIM_W  = 9;
    localparam int TGT_DIM_W  = 13;
    localparam int PIX_W      = 32;
    localparam int CFG_ADDR_W = 4;
    localparam int APB_DATA_W = 32;
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [1:0] {
        REG_SOURCE_WIDTH  = 2'd0,
        REG_SOURCE_HEIGHT = 2'd1,
        REG_TARGET_WIDTH  = 2'd2,
        REG_TARGET_HEIGHT = 2'd3
    } reg_idx_t;

    typedef enum logic [1:0] {
        KIND_WRITE   = 2'd0,
        KIND_RANGE   = 2'd1,
        KIND_REQUEST = 2'd2
    } item_kind_t;

    typedef struct packed {
        item_kind_t         kind;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [PIX_W-1:0]   pixel;
    } queue_item_t;

    typedef struct packed {
        logic        valid;
        queue_item_t item;
    } queue_head_t;

    // Effective image geometry after saturation of the size registers.
    typedef struct packed {
        logic [TGT_DIM_W-1:0] sw;
        logic [TGT_DIM_W-1:0] sh;
        logic [TGT_DIM_W-1:0] tw;
        logic [TGT_DIM_W-1:0] th;
    } geom_t;

    function automatic logic [TGT_DIM_W-1:0] clamp_dim(input logic [TGT_DIM_W-1:0] v,
                                                       input logic [TGT_DIM_W-1:0] hi);
        logic [TGT_DIM_W-1:0] r;
        if (v == '0)
        begin
            r = TGT_DIM_W'(1);
        end
        else if (v > hi)
        begin
            r = hi;
        end
        else
        begin
            r = v;
        end
        return r;
    endfunction

endpackage
`default_nettype wire

>>> src/awr_in_if.sv
// Input channel of the resize core: one pixel write or one output request per item.
// Depends on awr_pkg for field widths.
`default_nettype none
interface awr_in_if;
    import awr_pkg::*;
    logic               valid;
    logic               ready;
    logic               operation;
    logic [COORD_W-1:0] coord_x;
    logic [COORD_W-1:0] coord_y;
    logic [CHAN_W-1:0]  red_in;
    logic [CHAN_W-1:0]  green_in;
    logic [CHAN_W-1:0]  blue_in;
    logic [CHAN_W-1:0]  alpha_in;

    modport source(output valid, operation, coord_x, coord_y, red_in, green_in, blue_in,
                   alpha_in, input ready);
    modport sink(input valid, operation, coord_x, coord_y, red_in, green_in, blue_in,
                 alpha_in, output ready);
endinterface
`default_nettype wire

>>> src/awr_out_if.sv
// Result channel of the resize core: one averaged RGBA pixel per request.
// Depends on awr_pkg for field widths.
`default_nettype none
interface awr_out_if;
    import awr_pkg::*;
    logic              valid;
    logic              ready;
    logic [CHAN_W-1:0] red_out;
    logic [CHAN_W-1:0] green_out;
    logic [CHAN_W-1:0] blue_out;
    logic [CHAN_W-1:0] alpha_out;
    logic              range_error;

    modport source(output valid, red_out, green_out, blue_out, alpha_out, range_error,
                   input ready);
    modport sink(input valid, red_out, green_out, blue_out, alpha_out, range_error,
                 output ready);
endinterface
`default_nettype wire

>>> src/awr_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module awr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                                   clk,
    input  wire logic                                   we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                       wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                       rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;
endmodule
`default_nettype wire

>>> src/awr_div.sv
// Restoring divider that produces a bounded quotient one bit per cycle.
// No dependencies; the caller guarantees num < den * 2**QUO_W.
`default_nettype none
module awr_div #(
    parameter int NUM_W = 32,
    parameter int DEN_W = 16,
    parameter int QUO_W = 9
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [NUM_W-1:0] num,
    input  wire logic [DEN_W-1:0] den,
    output logic                  busy,
    output logic                  done,
    output logic      [QUO_W-1:0] quo
);
    localparam int CMP_W  = (NUM_W > DEN_W + QUO_W) ? NUM_W : DEN_W + QUO_W;
    localparam int STEP_W = $clog2(QUO_W + 1);

    logic [CMP_W-1:0]  rem_reg;
    logic [CMP_W-1:0]  dsh_reg;
    logic [QUO_W-1:0]  quo_reg;
    logic [STEP_W-1:0] step_reg;
    logic              busy_reg;
    logic              done_reg;
    logic              take;

    assign take = (rem_reg >= dsh_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                rem_reg  <= CMP_W'(num);
                dsh_reg  <= CMP_W'(den) << (QUO_W - 1);
                quo_reg  <= '0;
                step_reg <= STEP_W'(QUO_W);
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                if (take)
                begin
                    rem_reg <= rem_reg - dsh_reg;
                end
                quo_reg  <= {quo_reg[QUO_W-2:0], take};
                dsh_reg  <= dsh_reg >> 1;
                step_reg <= step_reg - STEP_W'(1);
                if (step_reg == STEP_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign quo  = quo_reg;
endmodule
`default_nettype wire

>>> src/awr_front.sv
// Front end: accepts input requests, classifies them and holds them in a short queue.
// Depends on awr_pkg and awr_in_if.
`default_nettype none
module awr_front #(
    parameter int MAX_SOURCE_WIDTH  = 256,
    parameter int MAX_SOURCE_HEIGHT = 256
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    awr_in_if.sink             pix_in,
    input  wire awr_pkg::geom_t geom,
    input  wire logic          pop,
    output awr_pkg::queue_head_t head
);
    import awr_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    queue_item_t      slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             accept;
    logic             push;
    queue_item_t      item;

    assign pix_in.ready = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign accept       = pix_in.valid && pix_in.ready;

    // Writes outside the store are dropped here and never reach the back end.
    always_comb
    begin
        item.x     = pix_in.coord_x;
        item.y     = pix_in.coord_y;
        item.pixel = {pix_in.alpha_in, pix_in.blue_in, pix_in.green_in, pix_in.red_in};
        item.kind  = KIND_WRITE;
        push       = 1'b0;
        if (!pix_in.operation)
        begin
            push = accept
                && ({1'b0, pix_in.coord_x} < TGT_DIM_W'(MAX_SOURCE_WIDTH))
                && ({1'b0, pix_in.coord_y} < TGT_DIM_W'(MAX_SOURCE_HEIGHT));
        end
        else
        begin
            push = accept;
            if (({1'b0, pix_in.coord_x} >= geom.tw) || ({1'b0, pix_in.coord_y} >= geom.th))
            begin
                item.kind = KIND_RANGE;
            end
            else
            begin
                item.kind = KIND_REQUEST;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                slot_reg[wr_ptr_reg] <= item;
                wr_ptr_reg           <= wr_ptr_reg + PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            count_reg <= count_reg + CNT_W'(push) - CNT_W'(pop);
        end
    end

    assign head.valid = (count_reg != '0);
    assign head.item  = slot_reg[rd_ptr_reg];
endmodule
`default_nettype wire

>>> src/awr_back.sv
// Back end: executes queued items, walks output boxes over the source store and averages.
// Depends on awr_pkg, awr_out_if, awr_ram, awr_div and the assertion macro header.
`default_nettype none
`include "alpha_weighted_area_resize_core_macros.svh"
module awr_back #(
    parameter int MAX_SOURCE_WIDTH  = 256,
    parameter int MAX_SOURCE_HEIGHT = 256
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire awr_pkg::queue_head_t head,
    input  wire awr_pkg::geom_t       geom,
    output logic                      pop,
    awr_out_if.source                 pix_out
);
    import awr_pkg::*;

    localparam int RAM_DEPTH = MAX_SOURCE_WIDTH * MAX_SOURCE_HEIGHT;
    localparam int RAM_AW    = (RAM_DEPTH > 1) ? $clog2(RAM_DEPTH) : 1;
    localparam int IX_W      = $clog2(MAX_SOURCE_WIDTH + 1);
    localparam int IY_W      = $clog2(MAX_SOURCE_HEIGHT + 1);
    localparam int SUMW_W    = $clog2(RAM_DEPTH + 1);
    localparam int SUMA_W    = SUMW_W + CHAN_W;
    localparam int SUMC_W    = SUMA_W + CHAN_W;
    localparam int POS_W     = COORD_W + TGT_DIM_W + 1;
    localparam int OVP_W     = 2 * TGT_DIM_W;
    localparam int SRC_MAX   = (MAX_SOURCE_WIDTH > MAX_SOURCE_HEIGHT) ?
                               MAX_SOURCE_WIDTH : MAX_SOURCE_HEIGHT;
    localparam int QW0       = $clog2(SRC_MAX + 1) + 1;
    localparam int QW        = (QW0 > 9) ? QW0 : 9;
    localparam int NUM_W     = (SUMC_W + 2 > POS_W) ? SUMC_W + 2 : POS_W;
    localparam int DEN_W     = (SUMA_W + 1 > TGT_DIM_W) ? SUMA_W + 1 : TGT_DIM_W;

    typedef enum logic [3:0] {
        ST_IDLE, ST_MUL, ST_DIV_GO, ST_DIV_WAIT, ST_ROW,
        ST_RD, ST_WT, ST_AW, ST_ACC, ST_OUT
    } state_t;

    typedef enum logic [2:0] {
        DS_I0, DS_I1, DS_J0, DS_J1, DS_RED, DS_GREEN, DS_BLUE, DS_ALPHA
    } div_step_t;

    state_t              state_reg;
    div_step_t           div_step_reg;
    logic [COORD_W-1:0]  x_reg;
    logic [COORD_W-1:0]  y_reg;
    logic [POS_W-1:0]    xlo_reg;
    logic [POS_W-1:0]    ylo_reg;
    logic [IX_W-1:0]     i0_reg;
    logic [IX_W-1:0]     i1_reg;
    logic [IX_W-1:0]     i_reg;
    logic [IY_W-1:0]     j_reg;
    logic [IY_W-1:0]     j1_reg;
    logic [SUMW_W-1:0]   row_base_reg;
    logic [RAM_AW-1:0]   rd_addr_reg;
    logic [TGT_DIM_W-1:0] wy_reg;
    logic [TGT_DIM_W-1:0] ox_reg;
    logic [SUMW_W-1:0]   w_reg;
    logic [SUMA_W-1:0]   aw_reg;
    logic [PIX_W-1:0]    pix_reg;
    logic [SUMW_W-1:0]   sum_w_reg;
    logic [SUMA_W-1:0]   sum_aw_reg;
    logic [SUMC_W-1:0]   sum_r_reg;
    logic [SUMC_W-1:0]   sum_g_reg;
    logic [SUMC_W-1:0]   sum_b_reg;
    logic [CHAN_W-1:0]   res_r_reg;
    logic [CHAN_W-1:0]   res_g_reg;
    logic [CHAN_W-1:0]   res_b_reg;
    logic [CHAN_W-1:0]   res_a_reg;
    logic                out_valid_reg;
    logic [CHAN_W-1:0]   out_r_reg;
    logic [CHAN_W-1:0]   out_g_reg;
    logic [CHAN_W-1:0]   out_b_reg;
    logic [CHAN_W-1:0]   out_a_reg;
    logic                out_err_reg;

    logic                out_free;
    logic                out_load;
    logic                ram_we;
    logic [RAM_AW-1:0]   ram_waddr;
    logic [PIX_W-1:0]    ram_rdata;
    logic                div_start;
    logic                div_busy;
    logic                div_done;
    logic [QW-1:0]       div_quo;
    logic [NUM_W-1:0]    div_num;
    logic [DEN_W-1:0]    div_den;
    logic [TGT_DIM_W-1:0] ox_now;
    logic [TGT_DIM_W-1:0] wy_now;
    logic [CHAN_W-1:0]   quo_byte;

    // Overlap of the span [a, a+span) with the box [lo, hi).
    function automatic logic [TGT_DIM_W-1:0] overlap(input logic [POS_W-1:0]     a,
                                                     input logic [TGT_DIM_W-1:0] span,
                                                     input logic [POS_W-1:0]     lo,
                                                     input logic [POS_W-1:0]     hi);
        logic [POS_W-1:0] b;
        logic [POS_W-1:0] s;
        logic [POS_W-1:0] e;
        b = a + POS_W'(span);
        s = (a > lo) ? a : lo;
        e = (b < hi) ? b : hi;
        return (e > s) ? TGT_DIM_W'(e - s) : '0;
    endfunction

    assign out_free  = !out_valid_reg || pix_out.ready;
    // The result register takes a new result either for a flagged request or a finished box.
    assign out_load  = ((state_reg == ST_IDLE) && head.valid
                        && (head.item.kind == KIND_RANGE) && out_free)
                    || ((state_reg == ST_OUT) && out_free);
    assign ram_waddr = RAM_AW'(head.item.y * MAX_SOURCE_WIDTH + head.item.x);
    assign div_start = (state_reg == ST_DIV_GO);
    assign ox_now    = overlap(POS_W'(i_reg) * POS_W'(geom.tw), geom.tw,
                               xlo_reg, xlo_reg + POS_W'(geom.sw));
    assign wy_now    = overlap(POS_W'(j_reg) * POS_W'(geom.th), geom.th,
                               ylo_reg, ylo_reg + POS_W'(geom.sh));
    assign quo_byte  = div_quo[CHAN_W-1:0];

    always_comb
    begin
        pop    = 1'b0;
        ram_we = 1'b0;
        if ((state_reg == ST_IDLE) && head.valid)
        begin
            unique case (head.item.kind)
                KIND_WRITE:
                begin
                    pop    = 1'b1;
                    ram_we = 1'b1;
                end
                KIND_RANGE:   pop = out_free;
                KIND_REQUEST: pop = 1'b1;
                default:      pop = 1'b0;
            endcase
        end
    end

    // Operands of the shared divider: box bounds first, then the four averages.
    always_comb
    begin
        unique case (div_step_reg)
            DS_I0:
            begin
                div_num = NUM_W'(xlo_reg);
                div_den = DEN_W'(geom.tw);
            end
            DS_I1:
            begin
                div_num = NUM_W'(xlo_reg + POS_W'(geom.sw) + POS_W'(geom.tw) - POS_W'(1));
                div_den = DEN_W'(geom.tw);
            end
            DS_J0:
            begin
                div_num = NUM_W'(ylo_reg);
                div_den = DEN_W'(geom.th);
            end
            DS_J1:
            begin
                div_num = NUM_W'(ylo_reg + POS_W'(geom.sh) + POS_W'(geom.th) - POS_W'(1));
                div_den = DEN_W'(geom.th);
            end
            DS_RED:
            begin
                div_num = NUM_W'({sum_r_reg, 1'b0}) + NUM_W'(sum_aw_reg);
                div_den = DEN_W'({sum_aw_reg, 1'b0});
            end
            DS_GREEN:
            begin
                div_num = NUM_W'({sum_g_reg, 1'b0}) + NUM_W'(sum_aw_reg);
                div_den = DEN_W'({sum_aw_reg, 1'b0});
            end
            DS_BLUE:
            begin
                div_num = NUM_W'({sum_b_reg, 1'b0}) + NUM_W'(sum_aw_reg);
                div_den = DEN_W'({sum_aw_reg, 1'b0});
            end
            DS_ALPHA:
            begin
                div_num = NUM_W'({sum_aw_reg, 1'b0}) + NUM_W'(sum_w_reg);
                div_den = DEN_W'({sum_w_reg, 1'b0});
            end
            default:
            begin
                div_num = '0;
                div_den = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            div_step_reg  <= DS_I0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && pix_out.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (head.valid && (head.item.kind == KIND_RANGE) && out_free)
                    begin
                        out_r_reg     <= '0;
                        out_g_reg     <= '0;
                        out_b_reg     <= '0;
                        out_a_reg     <= '0;
                        out_err_reg   <= 1'b1;
                    end
                    else if (head.valid && (head.item.kind == KIND_REQUEST))
                    begin
                        x_reg     <= head.item.x;
                        y_reg     <= head.item.y;
                        state_reg <= ST_MUL;
                    end
                end
                ST_MUL:
                begin
                    xlo_reg      <= POS_W'(x_reg) * POS_W'(geom.sw);
                    ylo_reg      <= POS_W'(y_reg) * POS_W'(geom.sh);
                    sum_w_reg    <= '0;
                    sum_aw_reg   <= '0;
                    sum_r_reg    <= '0;
                    sum_g_reg    <= '0;
                    sum_b_reg    <= '0;
                    div_step_reg <= DS_I0;
                    state_reg    <= ST_DIV_GO;
                end
                ST_DIV_GO:
                begin
                    state_reg <= ST_DIV_WAIT;
                end
                ST_DIV_WAIT:
                begin
                    if (div_done)
                    begin
                        div_step_reg <= div_step_t'(div_step_reg + 3'd1);
                        // The last bound starts the walk; the alpha average ends the request.
                        state_reg    <= (div_step_reg == DS_J1) ? ST_ROW :
                                        ((div_step_reg == DS_ALPHA) ? ST_OUT : ST_DIV_GO);
                        unique case (div_step_reg)
                            DS_I0: i0_reg <= IX_W'(div_quo);
                            DS_I1: i1_reg <= (div_quo > QW'(geom.sw)) ?
                                             IX_W'(geom.sw) : IX_W'(div_quo);
                            DS_J0:
                            begin
                                j_reg        <= IY_W'(div_quo);
                                row_base_reg <= SUMW_W'(SUMW_W'(div_quo)
                                                * SUMW_W'(MAX_SOURCE_WIDTH));
                            end
                            DS_J1:    j1_reg    <= (div_quo > QW'(geom.sh)) ?
                                                   IY_W'(geom.sh) : IY_W'(div_quo);
                            DS_RED:   res_r_reg <= (sum_aw_reg == '0) ? '0 : quo_byte;
                            DS_GREEN: res_g_reg <= (sum_aw_reg == '0) ? '0 : quo_byte;
                            DS_BLUE:  res_b_reg <= (sum_aw_reg == '0) ? '0 : quo_byte;
                            DS_ALPHA: res_a_reg <= (sum_w_reg == '0) ? '0 : quo_byte;
                            default: i0_reg <= i0_reg;
                        endcase
                    end
                end
                ST_ROW:
                begin
                    if (j_reg >= j1_reg)
                    begin
                        div_step_reg <= DS_RED;
                        state_reg    <= ST_DIV_GO;
                    end
                    else
                    begin
                        wy_reg    <= wy_now;
                        i_reg     <= i0_reg;
                        state_reg <= ST_RD;
                    end
                end
                ST_RD:
                begin
                    rd_addr_reg <= RAM_AW'(row_base_reg + SUMW_W'(i_reg));
                    ox_reg      <= ox_now;
                    state_reg   <= ST_WT;
                end
                ST_WT:
                begin
                    w_reg     <= SUMW_W'(OVP_W'(ox_reg) * OVP_W'(wy_reg));
                    state_reg <= ST_AW;
                end
                ST_AW:
                begin
                    aw_reg    <= SUMA_W'(ram_rdata[PIX_W-1:PIX_W-CHAN_W]) * SUMA_W'(w_reg);
                    pix_reg   <= ram_rdata;
                    state_reg <= ST_ACC;
                end
                ST_ACC:
                begin
                    sum_r_reg  <= sum_r_reg + SUMC_W'(pix_reg[CHAN_W-1:0]) * SUMC_W'(aw_reg);
                    sum_g_reg  <= sum_g_reg
                                  + SUMC_W'(pix_reg[2*CHAN_W-1:CHAN_W]) * SUMC_W'(aw_reg);
                    sum_b_reg  <= sum_b_reg
                                  + SUMC_W'(pix_reg[3*CHAN_W-1:2*CHAN_W]) * SUMC_W'(aw_reg);
                    sum_aw_reg <= sum_aw_reg + aw_reg;
                    sum_w_reg  <= sum_w_reg + w_reg;
                    if ((i_reg + IX_W'(1)) < i1_reg)
                    begin
                        i_reg     <= i_reg + IX_W'(1);
                        state_reg <= ST_RD;
                    end
                    else
                    begin
                        j_reg        <= j_reg + IY_W'(1);
                        row_base_reg <= row_base_reg + SUMW_W'(MAX_SOURCE_WIDTH);
                        state_reg    <= ST_ROW;
                    end
                end
                ST_OUT:
                begin
                    if (out_free)
                    begin
                        out_r_reg     <= res_r_reg;
                        out_g_reg     <= res_g_reg;
                        out_b_reg     <= res_b_reg;
                        out_a_reg     <= res_a_reg;
                        out_err_reg   <= 1'b0;
                        state_reg     <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign pix_out.valid       = out_valid_reg;
    assign pix_out.red_out     = out_r_reg;
    assign pix_out.green_out   = out_g_reg;
    assign pix_out.blue_out    = out_b_reg;
    assign pix_out.alpha_out   = out_a_reg;
    assign pix_out.range_error = out_err_reg;

    awr_ram #(
        .WIDTH(PIX_W),
        .DEPTH(RAM_DEPTH)
    ) u_store (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(head.item.pixel),
        .raddr(rd_addr_reg),
        .rdata(ram_rdata)
    );

    awr_div #(
        .NUM_W(NUM_W),
        .DEN_W(DEN_W),
        .QUO_W(QW)
    ) u_div (
        .clk  (clk),
        .rst_n(rst_n),
        .start(div_start),
        .num  (div_num),
        .den  (div_den),
        .busy (div_busy),
        .done (div_done),
        .quo  (div_quo)
    );

    `AWR_ASSERT_IMP(a_div_start_idle, clk, rst_n, div_start, !div_busy)
    `AWR_ASSERT_IMP(a_walk_in_box, clk, rst_n, state_reg == ST_RD, i_reg < i1_reg)
    `AWR_ASSERT_NXT(a_result_loaded, clk, rst_n, (state_reg == ST_OUT) && out_free,
                    out_valid_reg && !out_err_reg && (state_reg == ST_IDLE))
endmodule
`default_nettype wire

>>> src/alpha_weighted_area_resize_core.sv
// With the back end idle, a pixel write passes the queue and lands in the store in the cycle after
// acceptance; an out-of-range request passes the queue into the result register once that is free.
// An output request runs the divider for the box bounds, walks the covered source rows with one
// store read per pixel, then runs the divider for the four averages; the bit-serial shared divider
// has a quotient width of 10 by default. One request at a time.
// Reset: size registers return to 1; the source store is undefined until written, no clear pass.
`default_nettype none
module alpha_weighted_area_resize_core #(
    parameter int MAX_SOURCE_WIDTH  = awr_pkg::MAX_SOURCE_WIDTH_DEF,
    parameter int MAX_SOURCE_HEIGHT = awr_pkg::MAX_SOURCE_HEIGHT_DEF,
    parameter int MAX_TARGET_DIM    = awr_pkg::MAX_TARGET_DIM_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    awr_in_if.sink                              pix_in,
    awr_out_if.source                           pix_out,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [awr_pkg::CFG_ADDR_W-1:0] paddr,
    input  wire logic [awr_pkg::APB_DATA_W-1:0] pwdata,
    output logic      [awr_pkg::APB_DATA_W-1:0] prdata,
    output logic                                pready
);
    import awr_pkg::*;

    // Raw register contents; the effective sizes are saturated copies of these.
    logic [SRC_DIM_W-1:0] src_width_reg;
    logic [SRC_DIM_W-1:0] src_height_reg;
    logic [TGT_DIM_W-1:0] tgt_width_reg;
    logic [TGT_DIM_W-1:0] tgt_height_reg;
    reg_idx_t             reg_sel;
    logic                 cfg_write;
    geom_t                geom;
    queue_head_t          head;
    logic                 pop;

    assign reg_sel   = reg_idx_t'(paddr[3:2]);
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_width_reg  <= SRC_DIM_W'(1);
            src_height_reg <= SRC_DIM_W'(1);
            tgt_width_reg  <= TGT_DIM_W'(1);
            tgt_height_reg <= TGT_DIM_W'(1);
        end
        else if (cfg_write)
        begin
            unique case (reg_sel)
                REG_SOURCE_WIDTH:  src_width_reg  <= pwdata[SRC_DIM_W-1:0];
                REG_SOURCE_HEIGHT: src_height_reg <= pwdata[SRC_DIM_W-1:0];
                REG_TARGET_WIDTH:  tgt_width_reg  <= pwdata[TGT_DIM_W-1:0];
                REG_TARGET_HEIGHT: tgt_height_reg <= pwdata[TGT_DIM_W-1:0];
                default:           src_width_reg  <= src_width_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            REG_SOURCE_WIDTH:  prdata = APB_DATA_W'(src_width_reg);
            REG_SOURCE_HEIGHT: prdata = APB_DATA_W'(src_height_reg);
            REG_TARGET_WIDTH:  prdata = APB_DATA_W'(tgt_width_reg);
            REG_TARGET_HEIGHT: prdata = APB_DATA_W'(tgt_height_reg);
            default:           prdata = '0;
        endcase
    end

    // Sizes outside the supported range saturate into it.
    assign geom.sw = clamp_dim(TGT_DIM_W'(src_width_reg), TGT_DIM_W'(MAX_SOURCE_WIDTH));
    assign geom.sh = clamp_dim(TGT_DIM_W'(src_height_reg), TGT_DIM_W'(MAX_SOURCE_HEIGHT));
    assign geom.tw = clamp_dim(tgt_width_reg, TGT_DIM_W'(MAX_TARGET_DIM));
    assign geom.th = clamp_dim(tgt_height_reg, TGT_DIM_W'(MAX_TARGET_DIM));

    // The front end takes requests while the back end is busy walking a box; the
    // queue between them keeps write and output request order intact.
    awr_front #(
        .MAX_SOURCE_WIDTH (MAX_SOURCE_WIDTH),
        .MAX_SOURCE_HEIGHT(MAX_SOURCE_HEIGHT)
    ) u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .pix_in(pix_in),
        .geom  (geom),
        .pop   (pop),
        .head  (head)
    );

    // The back end owns the source store, the shared divider and the result register.
    awr_back #(
        .MAX_SOURCE_WIDTH (MAX_SOURCE_WIDTH),
        .MAX_SOURCE_HEIGHT(MAX_SOURCE_HEIGHT)
    ) u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .head   (head),
        .geom   (geom),
        .pop    (pop),
        .pix_out(pix_out)
    );
endmodule
`default_nettype wire

>>> dv/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench of alpha_weighted_area_resize_core: it loads source pixels, requests
// resized RGBA pixels and compares every result against a predictor of the area average.
// Depends on awr_pkg and the awr_in_if / awr_out_if interfaces of the RTL.

typedef struct {
    bit        operation;
    bit [11:0] coord_x;
    bit [11:0] coord_y;
    bit [7:0]  red;
    bit [7:0]  green;
    bit [7:0]  blue;
    bit [7:0]  alpha;
} pixel_request_t;

typedef struct {
    bit [7:0] red;
    bit [7:0] green;
    bit [7:0] blue;
    bit [7:0] alpha;
    bit       range_error;
} resized_pixel_t;

// Shadow of the source store and size registers, and the queue of resized pixels due.
class resize_scoreboard;
    bit [31:0]      source_pixels [65536];
    bit             pixel_loaded [65536];
    bit [12:0]      size_reg [4];
    resized_pixel_t due_pixels [$];
    int             errors;

    function new();
        foreach (size_reg[k])
        begin
            size_reg[k] = 1;
        end
        errors = 0;
    endfunction

    function void write_size(awr_pkg::reg_idx_t idx, bit [31:0] value);
        if (idx == awr_pkg::REG_SOURCE_WIDTH || idx == awr_pkg::REG_SOURCE_HEIGHT)
        begin
            size_reg[idx] = value[8:0];
        end
        else
        begin
            size_reg[idx] = value[12:0];
        end
    endfunction

    // Saturated size as the block uses it.
    function longint unsigned dim(awr_pkg::reg_idx_t idx);
        longint unsigned hi;
        hi = (idx == awr_pkg::REG_SOURCE_WIDTH || idx == awr_pkg::REG_SOURCE_HEIGHT)
             ? 256 : 4096;
        if (size_reg[idx] == 0)
        begin
            return 1;
        end
        return (size_reg[idx] > hi) ? hi : size_reg[idx];
    endfunction

    function longint unsigned overlap(longint unsigned k, longint unsigned span,
                                      longint unsigned lo, longint unsigned hi);
        longint unsigned a, b, s, e;
        a = k * span;
        b = a + span;
        s = (a > lo) ? a : lo;
        e = (b < hi) ? b : hi;
        return (e > s) ? e - s : 0;
    endfunction

    // Works out the resized pixel; with only_probe set it just reports whether every
    // source pixel under the box has been loaded.
    function bit area_average(bit [11:0] x, bit [11:0] y, bit only_probe,
                              output resized_pixel_t res);
        longint unsigned sw, sh, tw, th, xlo, xhi, ylo, yhi, i0, i1, j0, j1;
        longint unsigned wy, w, aw, sum_r, sum_g, sum_b, sum_aw, sum_w;
        bit [31:0] p;
        sw = dim(awr_pkg::REG_SOURCE_WIDTH);
        sh = dim(awr_pkg::REG_SOURCE_HEIGHT);
        tw = dim(awr_pkg::REG_TARGET_WIDTH);
        th = dim(awr_pkg::REG_TARGET_HEIGHT);
        res = '{0, 0, 0, 0, 0};
        sum_r = 0; sum_g = 0; sum_b = 0; sum_aw = 0; sum_w = 0;
        if (x >= tw || y >= th)
        begin
            res.range_error = 1;
            return 1;
        end
        xlo = x * sw; xhi = xlo + sw;
        ylo = y * sh; yhi = ylo + sh;
        i0 = xlo / tw; i1 = (xhi + tw - 1) / tw;
        j0 = ylo / th; j1 = (yhi + th - 1) / th;
        if (i1 > sw) i1 = sw;
        if (j1 > sh) j1 = sh;
        for (longint unsigned j = j0; j < j1; j++)
        begin
            wy = overlap(j, th, ylo, yhi);
            for (longint unsigned i = i0; i < i1; i++)
            begin
                if (only_probe && !pixel_loaded[j * 256 + i])
                begin
                    return 0;
                end
                w  = overlap(i, tw, xlo, xhi) * wy;
                p  = source_pixels[j * 256 + i];
                aw = p[31:24] * w;
                sum_r  += p[7:0] * aw;
                sum_g  += p[15:8] * aw;
                sum_b  += p[23:16] * aw;
                sum_aw += aw;
                sum_w  += w;
            end
        end
        if (sum_aw > 0)
        begin
            res.red   = (2 * sum_r + sum_aw) / (2 * sum_aw);
            res.green = (2 * sum_g + sum_aw) / (2 * sum_aw);
            res.blue  = (2 * sum_b + sum_aw) / (2 * sum_aw);
        end
        if (sum_w > 0)
        begin
            res.alpha = (2 * sum_aw + sum_w) / (2 * sum_w);
        end
        return 1;
    endfunction

    function bit request_is_safe(bit [11:0] x, bit [11:0] y);
        resized_pixel_t unused;
        return area_average(x, y, 1, unused);
    endfunction

    function void note_request(pixel_request_t req);
        resized_pixel_t res;
        if (req.operation == 0)
        begin
            if (req.coord_x < 256 && req.coord_y < 256)
            begin
                source_pixels[req.coord_y * 256 + req.coord_x] =
                    {req.alpha, req.blue, req.green, req.red};
                pixel_loaded[req.coord_y * 256 + req.coord_x] = 1;
            end
        end
        else
        begin
            void'(area_average(req.coord_x, req.coord_y, 0, res));
            due_pixels.push_back(res);
        end
    endfunction

    function void check_pixel(resized_pixel_t got);
        resized_pixel_t exp_px;
        if (due_pixels.size() == 0)
        begin
            $error("resized pixel arrived with none outstanding");
            errors++;
            return;
        end
        exp_px = due_pixels.pop_front();
        if (got.red != exp_px.red)
        begin
            $error("red_out: expected %0d, got %0d", exp_px.red, got.red);
            errors++;
        end
        if (got.green != exp_px.green)
        begin
            $error("green_out: expected %0d, got %0d", exp_px.green, got.green);
            errors++;
        end
        if (got.blue != exp_px.blue)
        begin
            $error("blue_out: expected %0d, got %0d", exp_px.blue, got.blue);
            errors++;
        end
        if (got.alpha != exp_px.alpha)
        begin
            $error("alpha_out: expected %0d, got %0d", exp_px.alpha, got.alpha);
            errors++;
        end
        if (got.range_error != exp_px.range_error)
        begin
            $error("range_error: expected %0d, got %0d", exp_px.range_error,
                   got.range_error);
            errors++;
        end
    endfunction
endclass

module tb_top;
    import awr_pkg::*;

    // A new phase starts while fewer items than this plus 12 have been sent.
    localparam int RANDOM_REQUESTS = 1050;
    // Cycles without any handshake before the run is declared hung. The slowest request
    // here walks at most 64 loaded source pixels, so this leaves a wide margin.
    localparam int HANG_LIMIT = 50000;

    logic clk;
    logic rst_n;
    logic psel, penable, pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic pready;

    awr_in_if  in_if ();
    awr_out_if out_if ();

    alpha_weighted_area_resize_core DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .pix_in  (in_if),
        .pix_out (out_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    resize_scoreboard sb = new();

    int burst_left = 0;
    int sent = 0;
    int quiet_cycles = 0;
    int stall_cycle = 0;
    int stall_mode = 0;

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // The result side stalls on its own schedule, switching between always ready,
    // coin-flip ready and a long periodic stall.
    always @(negedge clk)
    begin
        stall_cycle <= stall_cycle + 1;
        if (stall_cycle % 200 == 0)
        begin
            stall_mode <= $urandom_range(0, 2);
        end
        case (stall_mode)
            0: out_if.ready <= 1'b1;
            1: out_if.ready <= 1'($urandom_range(0, 1));
            default: out_if.ready <= (stall_cycle % 16) < 3;
        endcase
    end

    // Results are sampled on the rising edge at which they are taken.
    always @(posedge clk)
    begin
        if (rst_n && out_if.valid && out_if.ready)
        begin
            sb.check_pixel('{out_if.red_out, out_if.green_out, out_if.blue_out,
                             out_if.alpha_out, out_if.range_error});
        end
    end

    // Watchdog: counts cycles in which neither channel nor the register port moves.
    always @(posedge clk)
    begin
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) || psel)
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles > HANG_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Register write: setup cycle, then access cycle until pready.
    task automatic write_reg(reg_idx_t idx, bit [31:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= CFG_ADDR_W'(4 * idx);
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        sb.write_size(idx, value);
    endtask

    task automatic idle_input(int cycles);
        @(negedge clk);
        in_if.valid <= 1'b0;
        repeat (cycles) @(negedge clk);
    endtask

    // Holds the sender until every outstanding resized pixel has been taken.
    task automatic wait_drained();
        idle_input(0);
        while (sb.due_pixels.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // Sends one request. The sender works in bursts; between bursts valid drops for a
    // random gap, which is sometimes zero so back-to-back bursts also occur.
    task automatic send(pixel_request_t req);
        if (burst_left == 0)
        begin
            if ($urandom_range(0, 3) != 0)
            begin
                idle_input($urandom_range(0, 10));
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        if (in_if.valid !== 1'b1 || burst_left >= 0)
        begin
            @(negedge clk);
        end
        in_if.valid     <= 1'b1;
        in_if.operation <= req.operation;
        in_if.coord_x   <= req.coord_x;
        in_if.coord_y   <= req.coord_y;
        in_if.red_in    <= req.red;
        in_if.green_in  <= req.green;
        in_if.blue_in   <= req.blue;
        in_if.alpha_in  <= req.alpha;
        do @(posedge clk); while (!in_if.ready);
        sb.note_request(req);
    endtask

    task automatic load_pixel(bit [11:0] x, bit [11:0] y, bit [7:0] r, bit [7:0] g,
                              bit [7:0] b, bit [7:0] a);
        send('{1'b0, x, y, r, g, b, a});
        sent++;
    endtask

    task automatic load_random_pixel(bit [11:0] x, bit [11:0] y);
        load_pixel(x, y, 8'($urandom), 8'($urandom), 8'($urandom),
                   ($urandom_range(0, 5) == 0) ? 8'd0 : 8'($urandom));
    endtask

    task automatic ask_pixel(bit [11:0] x, bit [11:0] y);
        send('{1'b1, x, y, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom)});
        sent++;
    endtask

    // At most one random output request: either anywhere in the 12-bit space, which mostly falls
    // out of range, or biased toward the origin so that it lands on loaded source pixels.
    task automatic random_request();
        bit [11:0] x, y;
        for (int tries = 0; tries < 30; tries++)
        begin
            if ($urandom_range(0, 4) == 0)
            begin
                x = 12'($urandom);
                y = 12'($urandom);
            end
            else
            begin
                x = 12'($urandom_range(0, int'(sb.dim(REG_TARGET_WIDTH)) - 1)
                        >> $urandom_range(0, 12));
                y = 12'($urandom_range(0, int'(sb.dim(REG_TARGET_HEIGHT)) - 1)
                        >> $urandom_range(0, 12));
            end
            if (sb.request_is_safe(x, y))
            begin
                ask_pixel(x, y);
                return;
            end
        end
    endtask

    initial
    begin
        int phase_no;
        int sw, sh, region_w, region_h;
        bit [31:0] cfg [4];

        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_if.valid = 1'b0;
        in_if.operation = 1'b0;
        in_if.coord_x = '0;
        in_if.coord_y = '0;
        in_if.red_in = '0;
        in_if.green_in = '0;
        in_if.blue_in = '0;
        in_if.alpha_in = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part at the reset geometry of one pixel in, one pixel out.
        load_pixel(0, 0, 8'd255, 8'd0, 8'd255, 8'd255);
        ask_pixel(0, 0);
        // Fully transparent source: colour must come back as zero.
        load_pixel(0, 0, 8'd255, 8'd255, 8'd255, 8'd0);
        ask_pixel(0, 0);
        // Writes outside the store are dropped and must not disturb pixel (0,0).
        load_pixel(12'd4095, 12'd4095, 8'd1, 8'd2, 8'd3, 8'd4);
        load_pixel(12'd256, 12'd0, 8'd9, 8'd9, 8'd9, 8'd9);
        load_pixel(12'd0, 12'd256, 8'd9, 8'd9, 8'd9, 8'd9);
        ask_pixel(0, 0);
        load_pixel(12'd255, 12'd255, 8'd0, 8'd0, 8'd0, 8'd255);
        load_pixel(0, 0, 8'd0, 8'd255, 8'd0, 8'd128);
        ask_pixel(0, 0);
        // Requests outside the target size raise the range flag.
        ask_pixel(1, 0);
        ask_pixel(0, 1);
        ask_pixel(12'd4095, 12'd4095);

        // Random phases, each under its own geometry. The first few pin the extremes,
        // including zero and oversized values that must saturate.
        phase_no = 0;
        while (sent < RANDOM_REQUESTS + 12)
        begin
            wait_drained();
            // A write produces no result, so allow any last write to settle in the store.
            repeat (30) @(posedge clk);
            case (phase_no)
                0: cfg = '{256, 1, 1, 1};
                1: cfg = '{1, 256, 4096, 4096};
                2: cfg = '{0, 0, 0, 0};
                3: cfg = '{511, 511, 8191, 8191};
                4: cfg = '{256, 256, 4096, 1};
                5: cfg = '{3, 5, 4095, 2};
                default:
                begin
                    cfg[0] = $urandom_range(1, 12);
                    cfg[1] = $urandom_range(1, 12);
                    cfg[2] = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 4096)
                                                         : $urandom_range(1, 20);
                    cfg[3] = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 4096)
                                                         : $urandom_range(1, 20);
                end
            endcase
            write_reg(REG_SOURCE_WIDTH, cfg[0]);
            write_reg(REG_SOURCE_HEIGHT, cfg[1]);
            write_reg(REG_TARGET_WIDTH, cfg[2]);
            write_reg(REG_TARGET_HEIGHT, cfg[3]);

            // Load at most an 8x8 corner of the source image; requests are then kept
            // to boxes that fall on loaded pixels.
            sw = int'(sb.dim(REG_SOURCE_WIDTH));
            sh = int'(sb.dim(REG_SOURCE_HEIGHT));
            region_w = (sw < 8) ? sw : 8;
            region_h = (sh < 8) ? sh : 8;
            for (int j = 0; j < region_h; j++)
            begin
                for (int i = 0; i < region_w; i++)
                begin
                    load_random_pixel(12'(i), 12'(j));
                end
            end

            for (int k = 0; k < 80; k++)
            begin
                // Every third phase the sender stops halfway until nothing is outstanding.
                if (k == 40 && phase_no % 3 == 1)
                begin
                    wait_drained();
                end
                case ($urandom_range(0, 9))
                    0:
                    begin
                        // Dropped write outside the store.
                        send('{1'b0, 12'($urandom_range(256, 4095)), 12'($urandom),
                               8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom)});
                        sent++;
                    end
                    1, 2:
                    begin
                        load_random_pixel(12'($urandom_range(0, region_w - 1)),
                                          12'($urandom_range(0, region_h - 1)));
                    end
                    default:
                    begin
                        random_request();
                    end
                endcase
            end
            phase_no++;
        end

        wait_drained();
        repeat (200) @(posedge clk);
        if (sb.errors == 0)
        begin
            $display("end of test: clean");
        end
        else
        begin
            $display("end of test: mismatches");
        end
        $finish;
    end
endmodule

>>> filelist.f
+incdir+src
src/awr_pkg.sv
src/awr_in_if.sv
src/awr_out_if.sv
src/awr_ram.sv
src/awr_div.sv
src/awr_front.sv
src/awr_back.sv
src/alpha_weighted_area_resize_core.sv
dv/tb_top.sv
